FILE: hw/rtl/gmd_pkg.sv
// shared types, constants and table functions for the gradient magnitude and direction core
package gmd_pkg;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam int CORDIC_STEPS = 50;
  localparam int XY_W = 49;
  localparam int Z_W = 64;
  localparam int ABS_W = 17;
  localparam int SQ_W = 32;
  localparam int MAG_W = 15;
  localparam int ANGLE_W = 16;
  localparam int CORDIC_LATENCY = CORDIC_STEPS + 4;
  localparam int ISQRT_LATENCY = 18;

  localparam logic REG_NEGATE_X = 1'b0;
  localparam logic REG_NEGATE_Y = 1'b1;

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic zero;
    logic ax_zero;
    logic ay_zero;
  } gmd_quad_t;

  // restoring division, elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in q60 from its series
  function automatic logic signed [63:0] atan_pow2(int i);
    logic signed [63:0] sum;
    logic [63:0] term;
    int sh;
    sum = '0;
    if (i == 0) begin
      sum = signed'(PI_Q60 >> 2);
    end else begin
      for (int k = 0; k < 64; k++) begin
        sh = i * (2 * k + 1);
        if (sh <= 60) begin
          term = udiv64(64'd1 << (60 - sh), 64'(2 * k + 1));
          if (k % 2 == 1) sum = sum - signed'(term);
          else sum = sum + signed'(term);
        end
      end
    end
    return sum;
  endfunction

endpackage

FILE: hw/rtl/gradient_magnitude_direction_core.sv
// top level: gradient magnitude and full-circle direction, one pixel per clock
// the result strobe done follows start through the registered pipeline described below
// throughput: one transaction per cycle, busy is always low
// the depth is set by the 50-step cordic chain plus input and angle rounding stages
// reset clears the valid pipeline, negate_x to 0 and negate_y to 1
module gradient_magnitude_direction_core #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [15:0]          grad_x,
  input  logic signed [15:0]          grad_y,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic                        cfg_data,
  output logic                        done,
  output logic [gmd_pkg::MAG_W-1:0]   grad_magnitude,
  output logic [gmd_pkg::ANGLE_W-1:0] grad_angle
);

  localparam int AW = gmd_pkg::ABS_W;
  localparam int MAG_DELAY = gmd_pkg::CORDIC_LATENCY - gmd_pkg::ISQRT_LATENCY;

  logic negate_x, negate_y;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      negate_x <= 1'b0;
      negate_y <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gmd_pkg::REG_NEGATE_X: negate_x <= cfg_data;
        gmd_pkg::REG_NEGATE_Y: negate_y <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [AW-1:0] sx, sy;
  logic [AW-1:0]        abs_x, abs_y;
  assign sx = negate_x ? -AW'(grad_x) : AW'(grad_x);
  assign sy = negate_y ? -AW'(grad_y) : AW'(grad_y);
  assign abs_x = sx[AW-1] ? $unsigned(-sx) : $unsigned(sx);
  assign abs_y = sy[AW-1] ? $unsigned(-sy) : $unsigned(sy);

  logic                        a_valid;
  logic [AW-1:0]               a_ax, a_ay;
  gmd_pkg::gmd_quad_t          a_quad;
  logic [gmd_pkg::SQ_W-1:0]    a_sqx, a_sqy;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else a_valid <= start;
  end

  always_ff @(posedge clk) begin
    a_ax <= abs_x;
    a_ay <= abs_y;
    a_quad.x_neg <= sx[AW-1];
    a_quad.y_neg <= sy[AW-1];
    a_quad.zero <= (abs_x == '0) && (abs_y == '0);
    a_quad.ax_zero <= (abs_x == '0);
    a_quad.ay_zero <= (abs_y == '0);
    a_sqx <= $unsigned(gmd_pkg::SQ_W'(grad_x) * gmd_pkg::SQ_W'(grad_x));
    a_sqy <= $unsigned(gmd_pkg::SQ_W'(grad_y) * gmd_pkg::SQ_W'(grad_y));
  end

  logic [gmd_pkg::MAG_W-1:0] mag;
  logic [gmd_pkg::MAG_W-1:0] mag_dly [0:MAG_DELAY-1];

  gmd_isqrt u_isqrt (
    .clk  (clk),
    .sq_x (a_sqx),
    .sq_y (a_sqy),
    .mag  (mag)
  );

  always_ff @(posedge clk) begin
    mag_dly[0] <= mag;
    for (int k = 1; k < MAG_DELAY; k++) mag_dly[k] <= mag_dly[k-1];
  end

  assign grad_magnitude = mag_dly[MAG_DELAY-1];

  gmd_cordic #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .ax        (a_ax),
    .ay        (a_ay),
    .quad      (a_quad),
    .out_valid (done),
    .angle     (grad_angle)
  );

endmodule

FILE: hw/rtl/gmd_isqrt.sv
// pipelined rounded integer square root with saturation
module gmd_isqrt (
  input  logic                      clk,
  input  logic [gmd_pkg::SQ_W-1:0]  sq_x,
  input  logic [gmd_pkg::SQ_W-1:0]  sq_y,
  output logic [gmd_pkg::MAG_W-1:0] mag
);

  localparam int ROOT_W = 16;
  localparam int REM_W = 33;

  logic [ROOT_W-1:0] root [0:ROOT_W];
  logic [REM_W-1:0]  rem  [0:ROOT_W];

  always_ff @(posedge clk) begin
    root[0] <= '0;
    rem[0]  <= REM_W'(sq_x) + REM_W'(sq_y);
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
    localparam int B = ROOT_W - 1 - j;
    logic [REM_W-1:0] delta;
    assign delta = (REM_W'(root[j]) << (B + 1)) + (REM_W'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (delta <= rem[j]) begin
        rem[j+1]  <= rem[j] - delta;
        root[j+1] <= root[j] | (ROOT_W'(1) << B);
      end else begin
        rem[j+1]  <= rem[j];
        root[j+1] <= root[j];
      end
    end
  end

  logic [ROOT_W:0] rounded;
  assign rounded = (rem[ROOT_W] > REM_W'(root[ROOT_W])) ? ({1'b0, root[ROOT_W]} + 1'b1)
                                                         : {1'b0, root[ROOT_W]};

  always_ff @(posedge clk) begin
    if (rounded > (ROOT_W+1)'(32767)) mag <= '1;
    else mag <= rounded[gmd_pkg::MAG_W-1:0];
  end

endmodule

FILE: hw/rtl/gmd_cordic.sv
// pipelined vectoring cordic and full-circle angle quantization
module gmd_cordic #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [gmd_pkg::ABS_W-1:0]   ax,
  input  logic [gmd_pkg::ABS_W-1:0]   ay,
  input  gmd_pkg::gmd_quad_t          quad,
  output logic                        out_valid,
  output logic [gmd_pkg::ANGLE_W-1:0] angle
);

  localparam int N = gmd_pkg::CORDIC_STEPS;
  localparam int XW = gmd_pkg::XY_W;
  localparam int ZW = gmd_pkg::Z_W;
  localparam int SHIFT = 60 - ANGLE_FRAC_BITS;
  localparam int Q_W = 64 - SHIFT;
  localparam logic [63:0] HALF = 64'd1 << (SHIFT - 1);
  localparam logic [63:0] HALF_PI = gmd_pkg::PI_Q60 >> 1;
  localparam logic [63:0] TWO_PI = gmd_pkg::PI_Q60 << 1;
  localparam logic [63:0] TWOPI_Q64 = (TWO_PI + HALF) >> SHIFT;
  localparam logic [Q_W-1:0] TWOPI_Q = TWOPI_Q64[Q_W-1:0];

  logic signed [XW-1:0] xs [0:N];
  logic signed [XW-1:0] ys [0:N];
  logic signed [ZW-1:0] zs [0:N];
  logic                 vs [0:N];
  gmd_pkg::gmd_quad_t   qs [0:N];

  assign xs[0] = {2'b00, ax, 30'd0};
  assign ys[0] = {2'b00, ay, 30'd0};
  assign zs[0] = '0;
  assign vs[0] = in_valid;
  assign qs[0] = quad;

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN_I = gmd_pkg::atan_pow2(i);
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) vs[i+1] <= 1'b0;
      else vs[i+1] <= vs[i];
    end
    always_ff @(posedge clk) begin
      qs[i+1] <= qs[i];
      if (ys[i] > 0) begin
        xs[i+1] <= xs[i] + dx;
        ys[i+1] <= ys[i] - dy;
        zs[i+1] <= zs[i] + ATAN_I;
      end else begin
        xs[i+1] <= xs[i] - dx;
        ys[i+1] <= ys[i] + dy;
        zs[i+1] <= zs[i] - ATAN_I;
      end
    end
  end

  logic               v1, v2, v3;
  logic [63:0]        zc;
  logic [63:0]        total;
  logic [Q_W-1:0]     q;
  logic [63:0]        rnd;
  gmd_pkg::gmd_quad_t q1, q2, q3;

  assign rnd = total + HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= vs[N];
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    q1 <= qs[N];
    q2 <= q1;
    q3 <= q2;
    priority if (qs[N].ax_zero) zc <= HALF_PI;
    else if (qs[N].ay_zero) zc <= '0;
    else if (zs[N] < 0) zc <= '0;
    else if ($unsigned(zs[N]) > HALF_PI) zc <= HALF_PI;
    else zc <= $unsigned(zs[N]);
    unique case ({q1.x_neg, q1.y_neg})
      2'b00:   total <= zc;
      2'b01:   total <= TWO_PI - zc;
      2'b10:   total <= gmd_pkg::PI_Q60 - zc;
      default: total <= gmd_pkg::PI_Q60 + zc;
    endcase
    q <= rnd[63:SHIFT];
    priority if (q3.zero) angle <= '0;
    else if (q >= TWOPI_Q) angle <= gmd_pkg::ANGLE_W'(q - TWOPI_Q);
    else angle <= gmd_pkg::ANGLE_W'(q);
  end

endmodule

FILE: dv/gradient_magnitude_direction_checker.sv
// checker: predicts magnitude and direction per pixel and compares each result strobe
module gradient_magnitude_direction_checker #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic signed [15:0]          grad_x,
  input  logic signed [15:0]          grad_y,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic                        cfg_data,
  input  logic                        done,
  input  logic [gmd_pkg::MAG_W-1:0]   grad_magnitude,
  input  logic [gmd_pkg::ANGLE_W-1:0] grad_angle,
  output int                          mismatches,
  output int                          outstanding
);

  localparam longint PI60 = longint'(gmd_pkg::PI_Q60);

  typedef struct {
    logic [gmd_pkg::MAG_W-1:0]   mag;
    logic [gmd_pkg::ANGLE_W-1:0] ang;
  } pixel_result_t;

  pixel_result_t expected_pixels[$];
  logic flip_x, flip_y;

  function automatic longint arctan_step(int i);
    longint acc;
    int sh;
    acc = 0;
    if (i == 0) return PI60 / 4;
    for (int k = 0; k < 64; k++) begin
      sh = i * (2 * k + 1);
      if (sh > 60) break;
      if (k % 2 == 1) acc -= longint'((64'd1 << (60 - sh)) / 64'(2 * k + 1));
      else acc += longint'((64'd1 << (60 - sh)) / 64'(2 * k + 1));
    end
    return acc;
  endfunction

  function automatic longint quadrant_angle(longint ax, longint ay);
    longint x, y, z, sx, sy, a;
    if (ax == 0) return PI60 / 2;
    if (ay == 0) return 0;
    x = ax <<< 30;
    y = ay <<< 30;
    z = 0;
    for (int i = 0; i < 50; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      a = arctan_step(i);
      if (y > 0) begin
        x += sx; y -= sy; z += a;
      end else begin
        x -= sx; y += sy; z -= a;
      end
    end
    if (z < 0) z = 0;
    if (z > PI60 / 2) z = PI60 / 2;
    return z;
  endfunction

  function automatic pixel_result_t predict_pixel(logic signed [15:0] gx_in,
                                                   logic signed [15:0] gy_in,
                                                   logic nx, logic ny);
    pixel_result_t r;
    longint gx, gy, x, y, ang, total;
    logic [63:0] sq, root, q, full, half;
    int shift;
    gx = gx_in;
    gy = gy_in;
    sq = 64'(gx * gx + gy * gy);
    root = 0;
    for (int b = 16; b >= 0; b--)
      if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= sq) root |= 64'd1 << b;
    if (sq - root * root > root) root++;
    if (root > 32767) root = 32767;
    r.mag = root[gmd_pkg::MAG_W-1:0];
    x = nx ? -gx : gx;
    y = ny ? -gy : gy;
    shift = 60 - ANGLE_FRAC_BITS;
    half = 64'd1 << (shift - 1);
    if (x == 0 && y == 0) begin
      q = 0;
    end else begin
      ang = quadrant_angle(x < 0 ? -x : x, y < 0 ? -y : y);
      if (x >= 0) total = (y >= 0) ? ang : 2 * PI60 - ang;
      else total = (y >= 0) ? PI60 - ang : PI60 + ang;
      q = (64'(total) + half) >> shift;
      full = (64'(2 * PI60) + half) >> shift;
      if (q >= full) q -= full;
    end
    r.ang = q[gmd_pkg::ANGLE_W-1:0];
    return r;
  endfunction

  assign outstanding = expected_pixels.size();

  always @(posedge clk) begin
    pixel_result_t e;
    if (rst) begin
      flip_x = 1'b0;
      flip_y = 1'b1;
      mismatches = 0;
      expected_pixels.delete();
    end else begin
      if (done) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result mag %0d angle %0d", $time, grad_magnitude,
                   grad_angle);
          mismatches++;
        end else begin
          e = expected_pixels.pop_front();
          if (grad_magnitude !== e.mag) begin
            $display("%0t: magnitude expected %0d actual %0d", $time, e.mag, grad_magnitude);
            mismatches++;
          end
          if (grad_angle !== e.ang) begin
            $display("%0t: angle expected %0d actual %0d", $time, e.ang, grad_angle);
            mismatches++;
          end
        end
      end
      if (start && !busy)
        expected_pixels.push_back(predict_pixel(grad_x, grad_y, flip_x, flip_y));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gmd_pkg::REG_NEGATE_X) flip_x = cfg_data;
        else if (cfg_index == gmd_pkg::REG_NEGATE_Y) flip_y = cfg_data;
      end
    end
  end
endmodule

FILE: dv/gradient_magnitude_direction_core_test.sv
// testbench top: drives pixels and register writes, gives the verdict
module gradient_magnitude_direction_core_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [15:0] grad_x = '0;
  logic signed [15:0] grad_y = '0;
  logic cfg_valid = 1'b0;
  logic cfg_index = 1'b0;
  logic cfg_data = 1'b0;
  logic busy, cfg_ready, done;
  logic [gmd_pkg::MAG_W-1:0] grad_magnitude;
  logic [gmd_pkg::ANGLE_W-1:0] grad_angle;
  int mismatches, outstanding;
  int pixels_sent = 0;
  int gap_pct = 0;

  always #1 clk = ~clk;

  gradient_magnitude_direction_core dut (.*);
  gradient_magnitude_direction_checker chk (.*);

  task automatic send_pixel(logic signed [15:0] gx, logic signed [15:0] gy);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    grad_x <= gx;
    grad_y <= gy;
    do @(posedge clk); while (busy);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_component();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(64)) - 32);
      2: return 16'd0;
      3: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($signed($urandom_range(4000)) - 2000);
    endcase
  endfunction

  task automatic random_pixels(int n);
    for (int i = 0; i < n; i++) send_pixel(pick_component(), pick_component());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed corners under reset settings
    send_pixel(-16'sd32768, -16'sd32768);
    send_pixel(16'sd32767, 16'sd32767);
    send_pixel(16'sd32767, -16'sd32768);
    send_pixel(0, 0);
    send_pixel(0, 5);
    send_pixel(0, -5);
    send_pixel(7, 0);
    send_pixel(-7, 0);
    send_pixel(-16'sd32768, 0);
    send_pixel(0, 16'sd32767);
    send_pixel(3, 4);
    send_pixel(-3, 4);
    send_pixel(3, -4);
    send_pixel(-3, -4);
    send_pixel(1, -1);
    send_pixel(16'sd23170, 16'sd23170);
    send_pixel(16'sd23171, 16'sd23171);
    send_pixel(16'sd30000, -1);
    send_pixel(16'sd30000, 1);
    gap_pct = 26;
    random_pixels(200);
    drain();
    write_reg(gmd_pkg::REG_NEGATE_X, 1'b1);
    write_reg(gmd_pkg::REG_NEGATE_Y, 1'b1);
    gap_pct = 63;
    random_pixels(250);
    drain();
    write_reg(gmd_pkg::REG_NEGATE_Y, 1'b0);
    gap_pct = 0;
    random_pixels(250);
    drain();
    write_reg(gmd_pkg::REG_NEGATE_X, 1'b0);
    gap_pct = 20;
    random_pixels(250);
    drain();
    $display("ran %0d pixels over all four negate settings, with and without gaps",
             pixels_sent);
    if (mismatches == 0 && outstanding == 0) $display("[gradient_magnitude_direction_core] OK");
    else $display("[gradient_magnitude_direction_core] ERROR");
    $finish;
  end

  initial begin
    #400000;
    $display("[gradient_magnitude_direction_core] ERROR");
    $finish;
  end
endmodule
